FILE: design/bnpm_pkg.sv
package bnpm_pkg;

   localparam int PAY_W     = 8;
   localparam int SIZE_W    = 4;
   localparam int IDX_W     = 3;
   localparam int CNT_OUT_W = 7;
   localparam int DEF_MAX_SIZE = 8;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);

   typedef struct packed {
      logic signed [PAY_W-1:0] pay_a;
      logic signed [PAY_W-1:0] pay_b;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]     cell_row;
      logic [IDX_W-1:0]     cell_col;
      logic [1:0]           nash_marks;
      logic                 pareto_optimal;
      logic                 in_both;
      logic [CNT_OUT_W-1:0] both_count;
      logic                 last_result;
   } rsp_type;

endpackage

FILE: design/bnpm_ram.sv
module bnpm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/bimatrix_nash_pareto_marker.sv
// Bimatrix game marker: pure Nash equilibria and Pareto front.
// csr_ channel: one beat sets matrix_size n (0 acts as 1, above MAX_SIZE
//   saturates); csr_ready is always high; a write discards any partial load.
// req_ channel: one beat per cell (pay_a, pay_b), row-major. It is taken
//   whenever the block is loading; during evaluation req_stall is held high.
// rsp_ channel: after the n*n-th cell, n*n result beats follow in row-major
//   order; the last carries last_result and both_count.
// Evaluation reads the cell store through one single-port RAM, one entry a
//   cycle while it scans. Each cell passes S_FETCH, S_CUR, S_SCAN and S_EMIT:
//   one read of the cell itself, then a scan of every cell, then the result
//   is written to the output register.
// Results sit in an output register; while rsp_stall is high the next result
//   waits in S_EMIT until the register is taken, and no new scan starts.
// Reset (synchronous) sets n to 2, empties the load and drops rsp_valid. The
//   payoff store holds no reset value; every entry is loaded before use.
module bimatrix_nash_pareto_marker #(
   parameter int MAX_SIZE = bnpm_pkg::DEF_MAX_SIZE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bnpm_pkg::SIZE_W-1:0]     csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bnpm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bnpm_pkg::rsp_type               rsp_data
);
   import bnpm_pkg::*;

   localparam int CELLS  = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);

   typedef enum logic [2:0] {S_LOAD, S_FETCH, S_CUR, S_SCAN, S_EMIT} state_type;

   state_type state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0]  load_ff, load_in;
   logic [CNT_W-1:0]  k_ff, k_in, j_ff, j_in, pj_ff, pj_in;
   logic [IDX_W-1:0]  kr_ff, kr_in, kc_ff, kc_in, jr_ff, jr_in, jc_ff, jc_in;
   logic [IDX_W-1:0]  pr_ff, pr_in, pc_ff, pc_in;
   logic              plast_ff, plast_in;
   logic signed [PAY_W-1:0] cur_a_ff, cur_a_in, cur_b_ff, cur_b_in;
   logic              par_ff, par_in, cok_ff, cok_in, rok_ff, rok_in;
   logic [CNT_OUT_W-1:0] both_ff, both_in;
   logic              ov_ff, ov_in;
   rsp_type           out_ff, out_in;

   logic [SIZE_W-1:0] n_eff, n_m1;
   logic [CNT_W-1:0]  total;
   logic              we;
   logic [ADDR_W-1:0] addr;
   logic [2*PAY_W-1:0] rdata;
   logic signed [PAY_W-1:0] a2, b2;
   logic              self_hit, dom;
   logic [1:0]        marks;
   logic              inb;

   always_comb begin
      if (size_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(MAX_SIZE)) begin
         n_eff = SIZE_W'(MAX_SIZE);
      end else begin
         n_eff = size_ff;
      end
   end
   assign n_m1  = n_eff - SIZE_W'(1);
   assign total = CNT_W'(n_eff) * CNT_W'(n_eff);

   bnpm_ram #(.WIDTH(2 * PAY_W), .DEPTH(CELLS)) u_store (
      .clock (clock),
      .we    (we),
      .addr  (addr),
      .wdata ({req_data.pay_a, req_data.pay_b}),
      .rdata (rdata)
   );

   assign a2       = $signed(rdata[2*PAY_W-1:PAY_W]);
   assign b2       = $signed(rdata[PAY_W-1:0]);
   assign self_hit = (pj_ff == k_ff);
   assign dom      = ((cur_a_ff <= a2) && (cur_b_ff < b2)) ||
                     ((cur_a_ff < a2) && (cur_b_ff <= b2));
   assign marks    = {1'b0, cok_ff} + {1'b0, rok_ff};
   assign inb      = (marks == 2'd2) && par_ff;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_LOAD);
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in = state_ff;
      size_in  = size_ff;
      load_in  = load_ff;
      k_in = k_ff;  kr_in = kr_ff;  kc_in = kc_ff;
      j_in = j_ff;  jr_in = jr_ff;  jc_in = jc_ff;
      pj_in = pj_ff; pr_in = pr_ff; pc_in = pc_ff; plast_in = plast_ff;
      cur_a_in = cur_a_ff; cur_b_in = cur_b_ff;
      par_in = par_ff; cok_in = cok_ff; rok_in = rok_ff;
      both_in = both_ff;
      ov_in = ov_ff && rsp_stall;
      out_in = out_ff;
      we   = 1'b0;
      addr = j_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_LOAD: begin
            addr = load_ff[ADDR_W-1:0];
            if (req_valid) begin
               we = 1'b1;
               if (load_ff + CNT_W'(1) >= total) begin
                  load_in  = '0;
                  k_in = '0; kr_in = '0; kc_in = '0;
                  both_in  = '0;
                  state_in = S_FETCH;
               end else begin
                  load_in = load_ff + CNT_W'(1);
               end
            end
         end
         S_FETCH: begin
            addr = k_ff[ADDR_W-1:0];
            j_in = '0; jr_in = '0; jc_in = '0;
            state_in = S_CUR;
         end
         S_CUR, S_SCAN: begin
            if (state_ff == S_CUR) begin
               cur_a_in = a2;
               cur_b_in = b2;
               par_in = 1'b1; cok_in = 1'b1; rok_in = 1'b1;
            end else begin
               if (dom) begin
                  par_in = 1'b0;
               end
               if (!self_hit && (pc_ff == kc_ff) && (a2 >= cur_a_ff)) begin
                  cok_in = 1'b0;
               end
               if (!self_hit && (pr_ff == kr_ff) && (b2 >= cur_b_ff)) begin
                  rok_in = 1'b0;
               end
            end
            if ((state_ff == S_SCAN) && plast_ff) begin
               state_in = S_EMIT;
            end else begin
               pj_in = j_ff; pr_in = jr_ff; pc_in = jc_ff;
               plast_in = (j_ff + CNT_W'(1) == total);
               j_in = j_ff + CNT_W'(1);
               if ({1'b0, jc_ff} == n_m1) begin
                  jc_in = '0;
                  jr_in = jr_ff + IDX_W'(1);
               end else begin
                  jc_in = jc_ff + IDX_W'(1);
               end
               state_in = S_SCAN;
            end
         end
         S_EMIT: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in = 1'b1;
               out_in.cell_row       = kr_ff;
               out_in.cell_col       = kc_ff;
               out_in.nash_marks     = marks;
               out_in.pareto_optimal = par_ff;
               out_in.in_both        = inb;
               both_in = both_ff + CNT_OUT_W'(inb);
               if (k_ff + CNT_W'(1) == total) begin
                  out_in.both_count  = both_ff + CNT_OUT_W'(inb);
                  out_in.last_result = 1'b1;
                  state_in = S_LOAD;
               end else begin
                  out_in.both_count  = '0;
                  out_in.last_result = 1'b0;
                  state_in = S_FETCH;
               end
               k_in = k_ff + CNT_W'(1);
               if ({1'b0, kc_ff} == n_m1) begin
                  kc_in = '0;
                  kr_in = kr_ff + IDX_W'(1);
               end else begin
                  kc_in = kc_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = S_LOAD;
      endcase

      if (csr_valid) begin
         size_in = csr_data;
         load_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         size_ff  <= SIZE_RESET;
         load_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         load_ff  <= load_in;
         ov_ff    <= ov_in;
      end
      k_ff <= k_in;  kr_ff <= kr_in;  kc_ff <= kc_in;
      j_ff <= j_in;  jr_ff <= jr_in;  jc_ff <= jc_in;
      pj_ff <= pj_in; pr_ff <= pr_in; pc_ff <= pc_in; plast_ff <= plast_in;
      cur_a_ff <= cur_a_in; cur_b_ff <= cur_b_in;
      par_ff <= par_in; cok_ff <= cok_in; rok_ff <= rok_in;
      both_ff <= both_in;
      out_ff  <= out_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> req_stall)
      else $error("load beat taken during evaluation");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_result) |-> (rsp_data.both_count == '0))
      else $error("both_count set before last beat");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.in_both) |->
      (rsp_data.nash_marks == 2'd2 && rsp_data.pareto_optimal))
      else $error("in_both inconsistent with marks");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && plast_ff) |-> (j_ff == total))
      else $error("scan ended early");

endmodule

FILE: tb/tb_bimatrix_nash_pareto_marker.sv
`timescale 1ns / 100ps

module tb_bimatrix_nash_pareto_marker;
   import bnpm_pkg::*;

   localparam int CELL_MAX    = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int QUIET_MIN   = 8;

   typedef enum logic [1:0] {ITEM_CELL, ITEM_SIZE, ITEM_DRAIN} item_kind_type;

   typedef struct {
      item_kind_type     kind;
      req_type           payload;
      logic [SIZE_W-1:0] size;
   } item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;

   item_type pending[$];
   rsp_type  cell_reports[$];

   int pay_a_store[CELL_MAX];
   int pay_b_store[CELL_MAX];
   logic [SIZE_W-1:0] size_reg = SIZE_RESET;
   int cells_loaded = 0;

   int errors = 0, mismatches = 0, checked = 0, runs = 0, cells_taken = 0, size_writes = 0;
   int quiet = 0, burst_left = 0, gap_left = 0;
   int stall_mode = 0, stall_left = 0, mode_left = 0, cycles = 0;

   bimatrix_nash_pareto_marker i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic int game_size(logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > DEF_MAX_SIZE) return DEF_MAX_SIZE;
      return int'(v);
   endfunction

   task automatic mark_game();
      int n, total, best, hit, cnt, both;
      logic [1:0] marks[CELL_MAX];
      logic dominated;
      rsp_type r;
      n = game_size(size_reg);
      total = n * n;
      both = 0;
      for (int k = 0; k < CELL_MAX; k++) marks[k] = 2'd0;
      for (int c = 0; c < n; c++) begin
         best = pay_a_store[c];
         hit = 0;
         cnt = 0;
         for (int rr = 1; rr < n; rr++)
            if (pay_a_store[rr*n+c] > best) begin
               best = pay_a_store[rr*n+c];
               hit = rr;
            end
         for (int rr = 0; rr < n; rr++) if (pay_a_store[rr*n+c] == best) cnt++;
         if (cnt == 1) marks[hit*n+c]++;
      end
      for (int rr = 0; rr < n; rr++) begin
         best = pay_b_store[rr*n];
         hit = 0;
         cnt = 0;
         for (int c = 1; c < n; c++)
            if (pay_b_store[rr*n+c] > best) begin
               best = pay_b_store[rr*n+c];
               hit = c;
            end
         for (int c = 0; c < n; c++) if (pay_b_store[rr*n+c] == best) cnt++;
         if (cnt == 1) marks[rr*n+hit]++;
      end
      for (int k = 0; k < total; k++) begin
         dominated = 1'b0;
         for (int j = 0; j < total; j++)
            if ((pay_a_store[k] <= pay_a_store[j] && pay_b_store[k] < pay_b_store[j]) ||
                (pay_a_store[k] < pay_a_store[j] && pay_b_store[k] <= pay_b_store[j]))
               dominated = 1'b1;
         r.cell_row       = IDX_W'(k / n);
         r.cell_col       = IDX_W'(k % n);
         r.nash_marks     = marks[k];
         r.pareto_optimal = !dominated;
         r.in_both        = (marks[k] == 2'd2) && !dominated;
         if (r.in_both) both++;
         r.both_count     = '0;
         r.last_result    = 1'b0;
         if (k == total - 1) begin
            r.both_count  = CNT_OUT_W'(both);
            r.last_result = 1'b1;
         end
         cell_reports.insert(cell_reports.size(), r);
      end
      runs++;
   endtask

   task automatic load_cell(req_type c);
      int total;
      total = game_size(size_reg) ** 2;
      if (cells_loaded >= total) cells_loaded = 0;
      pay_a_store[cells_loaded] = int'(c.pay_a);
      pay_b_store[cells_loaded] = int'(c.pay_b);
      cells_loaded++;
      cells_taken++;
      if (cells_loaded == total) begin
         mark_game();
         cells_loaded = 0;
      end
   endtask

   always @(posedge clock) begin
      logic hold, nv, nc;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         hold = 1'b0;
         nv = 1'b0;
         nc = 1'b0;
         if (req_valid && !req_stall) begin
            load_cell(req_data);
            void'(pending.pop_front());
         end else if (req_valid) begin
            hold = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            size_reg = csr_data;
            cells_loaded = 0;
            size_writes++;
            void'(pending.pop_front());
         end
         if (cell_reports.size() == 0 && !rsp_valid) quiet++;
         else quiet = 0;
         if (hold) begin
            nv = 1'b1;
         end else if (csr_valid && !csr_ready) begin
            nc = 1'b1;
         end else if (pending.size() > 0) begin
            case (pending[0].kind)
               ITEM_CELL: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     nv = 1'b1;
                     req_data <= pending[0].payload;
                     if (burst_left == 0) burst_left = $urandom_range(1, 24);
                     burst_left--;
                     if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                  end
               end
               ITEM_SIZE: begin
                  if (quiet >= QUIET_MIN) begin
                     nc = 1'b1;
                     csr_data <= pending[0].size;
                  end
               end
               default: begin
                  if (quiet >= QUIET_MIN) void'(pending.pop_front());
               end
            endcase
         end
         req_valid <= nv;
         csr_valid <= nc;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      logic ns;
      if (rsp_valid && !rsp_stall) begin
         if (cell_reports.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected result beat %p", rsp_data);
         end else begin
            want = cell_reports.pop_front();
            checked++;
            if (rsp_data.cell_row !== want.cell_row || rsp_data.cell_col !== want.cell_col ||
                rsp_data.nash_marks !== want.nash_marks ||
                rsp_data.pareto_optimal !== want.pareto_optimal ||
                rsp_data.in_both !== want.in_both || rsp_data.both_count !== want.both_count ||
                rsp_data.last_result !== want.last_result) begin
               errors++;
               if (mismatches++ < 10) $display("result beat %0d: expected %p, got %p",
                                               checked, want, rsp_data);
            end
         end
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (stall_mode)
         0: ns = 1'b0;
         1: ns = ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_left == 0) stall_left = $urandom_range(1, 16);
            stall_left--;
            ns = (stall_left > 4);
         end
      endcase
      rsp_stall <= ns;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("bimatrix_nash_pareto_marker: mismatch");
         $finish;
      end
   end

   task automatic queue_cell(int a, int b);
      item_type it;
      it.kind = ITEM_CELL;
      it.payload.pay_a = PAY_W'(a);
      it.payload.pay_b = PAY_W'(b);
      it.size = '0;
      pending.insert(pending.size(), it);
   endtask

   task automatic queue_size(int v);
      item_type it;
      it.kind = ITEM_SIZE;
      it.payload = '0;
      it.size = SIZE_W'(v);
      pending.insert(pending.size(), it);
   endtask

   task automatic queue_drain();
      item_type it;
      it.kind = ITEM_DRAIN;
      it.payload = '0;
      it.size = '0;
      pending.insert(pending.size(), it);
   endtask

   function automatic int pick_payoff(int mode);
      int ext[4] = '{-128, 127, 0, -1};
      case (mode)
         0: return $urandom_range(0, 255) - 128;
         1: return $urandom_range(0, 4) - 2;
         default: return ext[$urandom_range(0, 3)];
      endcase
   endfunction

   initial begin
      int queued, n, mode, count, pick;
      queue_cell(-128, 127);
      queue_cell(127, -128);
      queue_cell(0, 0);
      queue_cell(127, 127);
      queue_size(1);
      queue_cell(-128, -128);
      queue_size(0);
      queue_cell(127, 127);
      queue_size(3);
      for (int k = 0; k < 9; k++) queue_cell(5, -5);
      queue_size(3);
      queue_cell(1, 2);
      queue_cell(3, 4);
      queue_size(2);
      queue_cell(-1, 1);
      queue_cell(1, -1);
      queue_cell(1, -1);
      queue_cell(-1, 1);
      queue_drain();
      queued = 0;
      while (queued < 400) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) n = $urandom_range(2, 4);
         else if (pick < 14) n = $urandom_range(0, 1);
         else if (pick < 17) n = $urandom_range(5, 7);
         else if (pick < 19) n = 8;
         else n = $urandom_range(9, 15);
         queue_size(n);
         mode = $urandom_range(0, 2);
         count = game_size(SIZE_W'(n)) ** 2;
         if (count > 1 && $urandom_range(0, 9) == 0) count = $urandom_range(1, count - 1);
         for (int k = 0; k < count; k++) queue_cell(pick_payoff(mode), pick_payoff(mode));
         queued += count;
         if ($urandom_range(0, 15) == 0) queue_drain();
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending.size() > 0 || cell_reports.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (cell_reports.size() > 0) errors++;
      $display("cells loaded %0d, games evaluated %0d, result beats checked %0d",
               cells_taken, runs, checked);
      $display("size writes %0d, errors %0d", size_writes, errors);
      if (errors == 0) $display("bimatrix_nash_pareto_marker: match");
      else $display("bimatrix_nash_pareto_marker: mismatch");
      $finish;
   end

endmodule
